// ===== sv/qse_pkg.sv =====
// ----------------------------------------------------------------------------
// qse_pkg
// shared constants for the quicksort engine: default store capacity and key
// width
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

endpackage

// ===== sv/quicksort_engine.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine
// batch sorter: collects signed keys, sorts them in place with a middle-pivot
// quicksort over an explicit range stack, then streams them out ascending
// ----------------------------------------------------------------------------
// loading: one key per cycle, busy stays low until the final key is taken
// sorting: each partition and each element visited is paced by the single key
//   memory read port and one shared comparator
// output: N results on consecutive cycles that the receiver cannot stall
// reset: synchronous, clears counts, stack pointer, flags and sequencer;
//   key and range memories hold their contents, no clearing pass
module quicksort_engine #(
  parameter int CAPACITY = qse_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = qse_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic                       in_final_key,
  output logic                       out_strobe,
  output logic signed [KEY_BITS-1:0] out_sorted_key,
  output logic                       out_last_out,
  output logic                       out_overflowed
);
  import qse_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SE_W  = 2 * IDX_W;
  localparam logic signed [IDX_W:0] ONE_S = 1;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_POP, S_RANGE, S_SWB, S_SWC, S_SWD, S_CHKL, S_CHKR,
    S_SWAP, S_FINR, S_FINA, S_FINB, S_PUSHR, S_PUSHL, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             drop_r, drop_nxt;
  logic             emit_v_r, emit_v_nxt;
  logic             emit_last_r, emit_last_nxt;
  logic             emit_ovf_r, emit_ovf_nxt;
  logic signed [IDX_W:0] left_r, left_nxt, right_r, right_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [KEY_BITS-1:0] pivot_r, pivot_nxt, vl_r, vl_nxt;

  logic                key_we;
  logic [IDX_W-1:0]    key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rd;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr, stk_raddr;
  logic [SE_W-1:0]     stk_wdata, stk_rd;

  logic signed [IDX_W:0] left_inc, right_dec, p_full;
  logic [IDX_W-1:0]      p_idx, p_inc, p_dec, srd_lo, srd_hi;
  logic [IDX_W:0]        mid_sum;
  logic [CNT_W-1:0]      sp_dec, count_dec;
  logic                  lt;

  qse_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  qse_ram #(.WIDTH(SE_W), .DEPTH(CAPACITY)) u_range_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  assign left_inc  = left_r + ONE_S;
  assign right_dec = right_r - ONE_S;
  assign p_full    = right_r + ONE_S;
  assign p_idx     = p_full[IDX_W-1:0];
  assign p_inc     = p_idx + IDX_W'(1);
  assign p_dec     = p_idx - IDX_W'(1);
  assign srd_lo    = stk_rd[SE_W-1:IDX_W];
  assign srd_hi    = stk_rd[IDX_W-1:0];
  assign mid_sum   = {1'b0, srd_lo} + {1'b0, srd_hi};
  assign sp_dec    = sp_r - CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);
  assign lt        = $signed(key_rd) < $signed(pivot_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    k_nxt         = k_r;
    drop_nxt      = drop_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = 1'b0;
    emit_ovf_nxt  = drop_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pivot_nxt     = pivot_r;
    vl_nxt        = vl_r;
    key_we        = 1'b0;
    key_waddr     = count_r[IDX_W-1:0];
    key_wdata     = in_key;
    key_raddr     = '0;
    stk_we        = 1'b0;
    stk_waddr     = sp_r[IDX_W-1:0];
    stk_wdata     = {IDX_W'(0), count_dec[IDX_W-1:0]};
    stk_raddr     = sp_dec[IDX_W-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          if (count_r < CNT_W'(CAPACITY)) begin
            key_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_final_key) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (count_r > CNT_W'(1)) begin
          stk_we = 1'b1;
          sp_nxt = sp_r + CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          sp_nxt    = sp_dec;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        lo_nxt    = srd_lo;
        hi_nxt    = srd_hi;
        mid_nxt   = mid_sum[IDX_W:1];
        key_raddr = mid_sum[IDX_W:1];
        if (srd_lo >= srd_hi) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_SWB;
        end
      end
      S_SWB: begin
        pivot_nxt = key_rd;
        key_raddr = hi_r;
        state_nxt = S_SWC;
      end
      S_SWC: begin
        key_we    = 1'b1;
        key_waddr = mid_r;
        key_wdata = key_rd;
        state_nxt = S_SWD;
      end
      S_SWD: begin
        key_we    = 1'b1;
        key_waddr = hi_r;
        key_wdata = pivot_r;
        key_raddr = lo_r;
        left_nxt  = $signed({1'b0, lo_r});
        right_nxt = $signed({1'b0, hi_r}) - ONE_S;
        state_nxt = S_CHKL;
      end
      S_CHKL: begin
        if (lt) begin
          left_nxt = left_inc;
          if (left_inc <= right_r) begin
            key_raddr = left_inc[IDX_W-1:0];
          end else begin
            state_nxt = S_FINR;
          end
        end else begin
          vl_nxt    = key_rd;
          key_raddr = right_r[IDX_W-1:0];
          state_nxt = S_CHKR;
        end
      end
      S_CHKR: begin
        if (!lt) begin
          right_nxt = right_dec;
          if (right_dec >= left_r) begin
            key_raddr = right_dec[IDX_W-1:0];
          end else begin
            state_nxt = S_FINR;
          end
        end else begin
          key_we    = 1'b1;
          key_waddr = left_r[IDX_W-1:0];
          key_wdata = key_rd;
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        key_we    = 1'b1;
        key_waddr = right_r[IDX_W-1:0];
        key_wdata = vl_r;
        left_nxt  = left_inc;
        right_nxt = right_dec;
        if (left_inc <= right_dec) begin
          key_raddr = left_inc[IDX_W-1:0];
          state_nxt = S_CHKL;
        end else begin
          state_nxt = S_FINR;
        end
      end
      S_FINR: begin
        key_raddr = p_idx;
        state_nxt = S_FINA;
      end
      S_FINA: begin
        key_we    = 1'b1;
        key_waddr = hi_r;
        key_wdata = key_rd;
        state_nxt = S_FINB;
      end
      S_FINB: begin
        key_we    = 1'b1;
        key_waddr = p_idx;
        key_wdata = pivot_r;
        state_nxt = S_PUSHR;
      end
      S_PUSHR: begin
        if (({1'b0, p_idx} + (IDX_W+1)'(1)) < {1'b0, hi_r}) begin
          stk_we    = 1'b1;
          stk_wdata = {p_inc, hi_r};
          sp_nxt    = sp_r + CNT_W'(1);
        end
        state_nxt = S_PUSHL;
      end
      S_PUSHL: begin
        if ({1'b0, p_idx} > ({1'b0, lo_r} + (IDX_W+1)'(1))) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_r, p_dec};
          sp_nxt    = sp_r + CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_EMIT: begin
        if (k_r < count_r) begin
          key_raddr     = k_r[IDX_W-1:0];
          emit_v_nxt    = 1'b1;
          emit_last_nxt = (k_r + CNT_W'(1)) == count_r;
          k_nxt         = k_r + CNT_W'(1);
        end
        if ((k_r + CNT_W'(1)) >= count_r) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          sp_nxt    = '0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sp_r        <= '0;
      k_r         <= '0;
      drop_r      <= 1'b0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
      emit_ovf_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      k_r         <= k_nxt;
      drop_r      <= drop_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
      emit_ovf_r  <= emit_ovf_nxt;
    end
    left_r  <= left_nxt;
    right_r <= right_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    pivot_r <= pivot_nxt;
    vl_r    <= vl_nxt;
  end

  assign busy           = state_r != S_LOAD;
  assign out_strobe     = emit_v_r;
  assign out_sorted_key = $signed(key_rd);
  assign out_last_out   = emit_last_r;
  assign out_overflowed = emit_ovf_r;

  // final key transaction starts the sort
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_final_key |=> busy)
    else $error("final key did not start the sort");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |-> out_strobe)
    else $error("last mark without a result");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(CAPACITY) && count_r <= CNT_W'(CAPACITY))
    else $error("stack pointer or key count out of range");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHKL || state_r == S_CHKR) |-> left_r <= right_r)
    else $error("scan indices crossed inside the scan");

endmodule

// ===== sv/qse_ram.sv =====
// ----------------------------------------------------------------------------
// qse_ram
// simple dual-port memory: one write port and one read port with registered
// read data
// ----------------------------------------------------------------------------
module qse_ram #(
  parameter int WIDTH = qse_pkg::KEY_BITS_DEF,
  parameter int DEPTH = qse_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import qse_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
